// File: hw/rtl/pid_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pid_pkg
// Types and codes shared by the decode stage and its port checker.
// ---------------------------------------------------------------------------
package pid_pkg;

	// opcodes
	localparam logic [5:0] OP_RTYPE     = 6'h00;
	localparam logic [5:0] OP_J         = 6'h02;
	localparam logic [5:0] OP_JAL       = 6'h03;
	localparam logic [5:0] OP_BEQ       = 6'h04;
	localparam logic [5:0] OP_BNE       = 6'h05;
	localparam logic [5:0] OP_ADDI      = 6'h08;
	localparam logic [5:0] OP_ADDI_NOVF = 6'h09;
	localparam logic [5:0] OP_SLTI      = 6'h0a;
	localparam logic [5:0] OP_SLTI_UNS  = 6'h0b;
	localparam logic [5:0] OP_ANDI      = 6'h0c;
	localparam logic [5:0] OP_ORI       = 6'h0d;
	localparam logic [5:0] OP_LUI       = 6'h0f;
	localparam logic [5:0] OP_LW        = 6'h23;
	localparam logic [5:0] OP_LBU       = 6'h24;
	localparam logic [5:0] OP_LHU       = 6'h25;
	localparam logic [5:0] OP_SB        = 6'h28;
	localparam logic [5:0] OP_SH        = 6'h29;
	localparam logic [5:0] OP_SW        = 6'h2b;
	localparam logic [5:0] OP_HALT      = 6'h3f;

	// funct codes
	localparam logic [5:0] FN_JR  = 6'h08;
	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_SUB = 6'h22;

	// control flag bit positions
	localparam int FL_REGDST   = 0;
	localparam int FL_ALUSRC   = 1;
	localparam int FL_MEMREAD  = 2;
	localparam int FL_MEMWRITE = 3;
	localparam int FL_REGWRITE = 4;
	localparam int FL_MEMTOREG = 5;
	localparam int FL_OVF      = 6;
	localparam int FL_BRANCH   = 7;

	// ALU op codes
	localparam logic [2:0] ALU_ADD = 3'd0;
	localparam logic [2:0] ALU_AND = 3'd1;
	localparam logic [2:0] ALU_OR  = 3'd3;
	localparam logic [2:0] ALU_R   = 3'd4;
	localparam logic [2:0] ALU_SLT = 3'd5;
	localparam logic [2:0] ALU_LUI = 3'd7;

	// access sizes
	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;

	localparam logic [4:0]  REG_RA     = 5'd31;
	localparam logic [31:0] EXC_VECTOR = 32'h0000_8000;

	// packed with the first field in the highest bits
	typedef struct packed {
		logic [31:0] wb_value;
		logic [4:0]  wb_dest;
		logic [31:0] mem_alu_value;
		logic        mem_is_load;
		logic [4:0]  mem_dest;
		logic [4:0]  ex_dest;
		logic [31:0] rt_value;
		logic [31:0] rs_value;
		logic [31:0] fetch_pc;
		logic [31:0] instr_word;
	} dec_item_t;

	typedef struct packed {
		logic        illegal;
		logic [31:0] redirect_target;
		logic        redirect;
		logic [31:0] pc_out;
		logic [31:0] operand_b;
		logic [31:0] operand_a;
		logic [31:0] imm_ext;
		logic [4:0]  dest_reg;
		logic [1:0]  access_size;
		logic [2:0]  alu_code;
		logic [7:0]  control_flags;
		logic        stall_res;
	} dec_result_t;

	localparam int ITEM_W  = $bits(dec_item_t);
	localparam int RES_W   = $bits(dec_result_t);
	localparam int IN_TW   = ((ITEM_W + 7) / 8) * 8;
	localparam int OUT_TW  = ((RES_W + 7) / 8) * 8;

endpackage
`default_nettype wire

// File: hw/rtl/pipelined_instruction_decode_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pipelined_instruction_decode_unit
// Decode stage of a five-stage MIPS-subset pipeline with hazard, forwarding
// and early branch resolution.
// ---------------------------------------------------------------------------
// One item enters per clock unless upstream is stalled. An accepted item is
// held in an input register, decoded by a single level of logic (field
// decode, hazard compares, operand forwarding, a 32-bit PC+4 adder, a 32-bit
// branch target adder and one 32-bit equality compare) and captured in an
// output register, which holds the result until it is taken. The output
// register parts the two sides: the block keeps taking items while a result
// waits, and stalls upstream only when both registers are full and the
// result is not taken. No reset sweep; ready is high straight out of reset.
module pipelined_instruction_decode_unit (
	input  wire  logic                        clk,
	input  wire  logic                        arst_n,
	input  wire  logic                        s_axis_tvalid,
	output logic                              s_axis_tready,
	// instr_word, fetch_pc, rs_value, rt_value, ex_dest, mem_dest,
	// mem_is_load, mem_alu_value, wb_dest, wb_value
	input  wire  logic [pid_pkg::IN_TW-1:0]   s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  wire  logic                        m_axis_tready,
	// stall_res, control_flags, alu_code, access_size, dest_reg, imm_ext,
	// operand_a, operand_b, pc_out, redirect, redirect_target, illegal, pad
	output logic [pid_pkg::OUT_TW-1:0]        m_axis_tdata
);

	pid_pkg::dec_item_t   item_s1;
	logic                 vld_s1;
	pid_pkg::dec_result_t res_s2;
	logic                 vld_s2;
	pid_pkg::dec_result_t res_d;

	logic adv_s2;
	logic adv_s1;

	assign adv_s2        = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv_s2;
	assign adv_s1        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_axis_tready)
				vld_s1 <= s_axis_tvalid;
			if (!vld_s2 || m_axis_tready)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			item_s1 <= pid_pkg::dec_item_t'(s_axis_tdata[pid_pkg::ITEM_W-1:0]);
		if (adv_s2)
			res_s2 <= res_d;
	end

	// decode
	logic [5:0]  op, fn;
	logic [4:0]  rs, rt, rd;
	logic [31:0] sx, pc4, jt, bt, s1v, s2v;
	logic [7:0]  fl;
	logic [2:0]  alu;
	logic [1:0]  sz;
	logic [4:0]  dest;
	logic [31:0] opa, opb;
	logic        bad, stall, go;
	logic [31:0] tgt;

	assign op  = item_s1.instr_word[31:26];
	assign rs  = item_s1.instr_word[25:21];
	assign rt  = item_s1.instr_word[20:16];
	assign rd  = item_s1.instr_word[15:11];
	assign fn  = item_s1.instr_word[5:0];
	assign sx  = {{16{item_s1.instr_word[15]}}, item_s1.instr_word[15:0]};
	assign pc4 = item_s1.fetch_pc + 32'd4;
	assign jt  = {pc4[31:28], item_s1.instr_word[25:0], 2'b00};
	assign bt  = item_s1.fetch_pc + {sx[29:0], 2'b00};

	always_comb begin
		fl   = '0;
		alu  = pid_pkg::ALU_ADD;
		sz   = pid_pkg::SZ_WORD;
		dest = rt;
		opa  = item_s1.rs_value;
		opb  = item_s1.rt_value;
		bad  = 1'b0;
		case (op)
			pid_pkg::OP_RTYPE: begin
				fl[pid_pkg::FL_REGDST]   = 1'b1;
				fl[pid_pkg::FL_REGWRITE] = 1'b1;
				fl[pid_pkg::FL_OVF]      = (fn == pid_pkg::FN_ADD) || (fn == pid_pkg::FN_SUB);
				alu  = pid_pkg::ALU_R;
				dest = rd;
			end
			pid_pkg::OP_ADDI, pid_pkg::OP_SLTI: begin
				fl[pid_pkg::FL_REGWRITE] = 1'b1;
				fl[pid_pkg::FL_ALUSRC]   = 1'b1;
				fl[pid_pkg::FL_OVF]      = 1'b1;
				alu = (op == pid_pkg::OP_SLTI) ? pid_pkg::ALU_SLT : pid_pkg::ALU_ADD;
			end
			pid_pkg::OP_ADDI_NOVF: begin
				fl[pid_pkg::FL_REGWRITE] = 1'b1;
				fl[pid_pkg::FL_ALUSRC]   = 1'b1;
			end
			pid_pkg::OP_ANDI: begin
				fl[pid_pkg::FL_REGWRITE] = 1'b1;
				fl[pid_pkg::FL_ALUSRC]   = 1'b1;
				alu = pid_pkg::ALU_AND;
			end
			pid_pkg::OP_ORI: begin
				fl[pid_pkg::FL_REGWRITE] = 1'b1;
				fl[pid_pkg::FL_ALUSRC]   = 1'b1;
				alu = pid_pkg::ALU_OR;
			end
			pid_pkg::OP_LUI: begin
				fl[pid_pkg::FL_REGWRITE] = 1'b1;
				fl[pid_pkg::FL_ALUSRC]   = 1'b1;
				alu = pid_pkg::ALU_LUI;
			end
			pid_pkg::OP_SLTI_UNS: begin
				fl[pid_pkg::FL_REGWRITE] = 1'b1;
				fl[pid_pkg::FL_ALUSRC]   = 1'b1;
				alu = pid_pkg::ALU_SLT;
			end
			pid_pkg::OP_BEQ, pid_pkg::OP_BNE: begin
				fl[pid_pkg::FL_BRANCH] = 1'b1;
			end
			pid_pkg::OP_LW, pid_pkg::OP_LBU, pid_pkg::OP_LHU: begin
				fl[pid_pkg::FL_MEMREAD]  = 1'b1;
				fl[pid_pkg::FL_ALUSRC]   = 1'b1;
				fl[pid_pkg::FL_MEMTOREG] = 1'b1;
				fl[pid_pkg::FL_REGWRITE] = 1'b1;
				if (op == pid_pkg::OP_LBU)
					sz = pid_pkg::SZ_BYTE;
				else if (op == pid_pkg::OP_LHU)
					sz = pid_pkg::SZ_HALF;
			end
			pid_pkg::OP_SW, pid_pkg::OP_SB, pid_pkg::OP_SH: begin
				fl[pid_pkg::FL_ALUSRC]   = 1'b1;
				fl[pid_pkg::FL_MEMWRITE] = 1'b1;
				if (op == pid_pkg::OP_SB)
					sz = pid_pkg::SZ_BYTE;
				else if (op == pid_pkg::OP_SH)
					sz = pid_pkg::SZ_HALF;
			end
			pid_pkg::OP_JAL: begin
				fl[pid_pkg::FL_REGWRITE] = 1'b1;
				dest = pid_pkg::REG_RA;
				opa  = pc4;
				opb  = '0;
			end
			pid_pkg::OP_J, pid_pkg::OP_HALT: begin
			end
			default: begin
				bad = 1'b1;
			end
		endcase
	end

	// hazards: EX writer on any source, or MEM load feeding a branch compare
	logic ex_rs, ex_rt, mem_rs, mem_rt, wb_rs, wb_rt;
	assign ex_rs  = (rs != 5'd0) && (item_s1.ex_dest == rs);
	assign ex_rt  = (rt != 5'd0) && (item_s1.ex_dest == rt);
	assign mem_rs = (rs != 5'd0) && (item_s1.mem_dest == rs);
	assign mem_rt = (rt != 5'd0) && (item_s1.mem_dest == rt);
	assign wb_rs  = (rs != 5'd0) && (item_s1.wb_dest == rs);
	assign wb_rt  = (rt != 5'd0) && (item_s1.wb_dest == rt);
	assign stall  = ex_rs || ex_rt ||
		(item_s1.mem_is_load && fl[pid_pkg::FL_BRANCH] && (mem_rs || mem_rt));

	// MEM is newer than WB
	assign s1v = mem_rs ? item_s1.mem_alu_value : (wb_rs ? item_s1.wb_value : item_s1.rs_value);
	assign s2v = mem_rt ? item_s1.mem_alu_value : (wb_rt ? item_s1.wb_value : item_s1.rt_value);

	always_comb begin
		go  = 1'b0;
		tgt = '0;
		if (op == pid_pkg::OP_BEQ) begin
			go  = (s1v == s2v);
			tgt = bt;
		end else if (op == pid_pkg::OP_BNE) begin
			go  = (s1v != s2v);
			tgt = bt;
		end else if (op == pid_pkg::OP_J || op == pid_pkg::OP_JAL) begin
			go  = 1'b1;
			tgt = jt;
		end else if (op == pid_pkg::OP_RTYPE && fn == pid_pkg::FN_JR) begin
			go  = 1'b1;
			tgt = s1v;
		end
	end

	always_comb begin
		res_d = '0;
		if (stall) begin
			res_d.stall_res = 1'b1;
		end else if (bad) begin
			res_d.redirect        = 1'b1;
			res_d.redirect_target = pid_pkg::EXC_VECTOR;
			res_d.illegal         = 1'b1;
		end else begin
			res_d.control_flags   = fl;
			res_d.alu_code        = alu;
			res_d.access_size     = sz;
			res_d.dest_reg        = dest;
			res_d.imm_ext         = sx;
			res_d.operand_a       = opa;
			res_d.operand_b       = opb;
			res_d.pc_out          = item_s1.fetch_pc;
			res_d.redirect        = go;
			res_d.redirect_target = go ? tgt : 32'd0;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {{(pid_pkg::OUT_TW - pid_pkg::RES_W){1'b0}}, res_s2};

endmodule
`default_nettype wire

// File: hw/rtl/pid_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pid_checker
// Port-level checks on the decode stage's result stream.
// ---------------------------------------------------------------------------
module pid_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        s_axis_tready,
	input wire logic                        m_axis_tvalid,
	input wire logic                        m_axis_tready,
	input wire logic [pid_pkg::OUT_TW-1:0]  m_axis_tdata
);

	pid_pkg::dec_result_t res;
	logic                 out_hs;

	assign res    = pid_pkg::dec_result_t'(m_axis_tdata[pid_pkg::RES_W-1:0]);
	assign out_hs = m_axis_tvalid && m_axis_tready;

	// a bubble carries nothing but the stall bit
	a_bubble_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs && res.stall_res |-> m_axis_tdata[pid_pkg::OUT_TW-1:1] == '0)
		else $error("bubble carries payload");

	// illegal opcode always redirects to the exception vector
	a_illegal_vec: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs && res.illegal |->
			res.redirect && res.redirect_target == pid_pkg::EXC_VECTOR && res.pc_out == '0)
		else $error("illegal without exception redirect");

	// no target without redirect
	a_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs && !res.redirect |-> res.redirect_target == '0)
		else $error("target set without redirect");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// with no result waiting the input side never blocks
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty output");

endmodule

bind pipelined_instruction_decode_unit pid_checker u_pid_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
